// File: rtl/nte_pkg.sv
`default_nettype none

package nte_pkg;

  localparam int unsigned CODE_W        = 16;
  localparam int unsigned WORD_W        = 32;
  localparam int unsigned PROD_W        = 2 * WORD_W;
  localparam int unsigned NIB_W         = 4;
  localparam int unsigned NUM_NIB       = CODE_W / NIB_W;
  localparam int unsigned NIB_VALS      = 1 << NIB_W;
  localparam int unsigned EMAX_DEF      = 5;
  localparam int unsigned FRAC_BITS_DEF = 24;

  // working format for building the tables: unsigned Q8.56
  localparam int unsigned WORK_FRAC     = 56;
  localparam int unsigned SERIES_TERMS  = 10;
  localparam int unsigned HALVINGS      = 8;

  typedef logic [NUM_NIB-1:0][NIB_VALS-1:0][WORD_W-1:0] tab_t;

  // one factor per nibble position, with its valid bit
  typedef struct packed {
    logic                          vld;
    logic [NUM_NIB-1:0][WORD_W-1:0] fac;
  } fac_beat_t;

  // Q8.56 times Q8.56, rounded half up
  function automatic logic [63:0] wmul(logic [63:0] a, logic [63:0] b);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    prod = prod + (128'd1 << (WORK_FRAC - 1));
    return prod[WORK_FRAC +: 64];
  endfunction

  // exp(+-emax*n/65535) in Q8.56: short series on arg/256, then squared eight times
  function automatic logic [63:0] wexp(int unsigned emax, logic [31:0] n, logic neg);
    logic [63:0] a;
    logic [63:0] q1;
    logic [63:0] r1;
    logic [63:0] s;
    logic [63:0] term;
    logic [63:0] acc;
    a    = 64'(emax) * {32'd0, n};
    q1   = (a << 24) / 64'd65535;
    r1   = (a << 24) % 64'd65535;
    s    = (q1 << 24) + ((r1 << 24) / 64'd65535);
    term = 64'd1 << WORK_FRAC;
    acc  = 64'd1 << WORK_FRAC;
    for (int unsigned m = 1; m <= SERIES_TERMS; m++) begin
      term = wmul(term, s) / 64'(m);
      if (neg && m[0]) begin
        acc = acc - term;
      end else begin
        acc = acc + term;
      end
    end
    for (int unsigned h = 0; h < HALVINGS; h++) begin
      acc = wmul(acc, acc);
    end
    return acc;
  endfunction

  function automatic logic [WORD_W-1:0] to_out(logic [63:0] v, int unsigned frac_bits);
    logic [64:0] r;
    r = ({1'b0, v} + (65'd1 << (WORK_FRAC - frac_bits - 1))) >> (WORK_FRAC - frac_bits);
    return (r > 65'({WORD_W{1'b1}})) ? {WORD_W{1'b1}} : r[WORD_W-1:0];
  endfunction

  function automatic tab_t build_tab(int unsigned emax, int unsigned frac_bits, logic neg);
    tab_t t;
    t = '0;
    for (int unsigned j = 0; j < NUM_NIB; j++) begin
      for (int unsigned i = 0; i < NIB_VALS; i++) begin
        t[j][i] = to_out(wexp(emax, 32'(i) << (NIB_W * j), neg), frac_bits);
      end
    end
    return t;
  endfunction

  // product back to frac_bits fraction bits, half up, saturating
  function automatic logic [WORD_W-1:0] rnd(logic [PROD_W-1:0] p, int unsigned frac_bits);
    logic [PROD_W:0] r;
    r = ({1'b0, p} + ((PROD_W+1)'(1) << (frac_bits - 1))) >> frac_bits;
    return (r > (PROD_W+1)'({WORD_W{1'b1}})) ? {WORD_W{1'b1}} : r[WORD_W-1:0];
  endfunction

endpackage

`default_nettype wire

// File: rtl/nte_lut.sv
`default_nettype none

module nte_lut #(
  parameter int unsigned EMAX      = nte_pkg::EMAX_DEF,
  parameter int unsigned FRAC_BITS = nte_pkg::FRAC_BITS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        vld_i,
  input  wire logic [nte_pkg::CODE_W-1:0]  code_i,
  input  wire logic                        action_i,
  output nte_pkg::fac_beat_t               beat_o
);

  localparam nte_pkg::tab_t PosTab = nte_pkg::build_tab(EMAX, FRAC_BITS, 1'b0);
  localparam nte_pkg::tab_t NegTab = nte_pkg::build_tab(EMAX, FRAC_BITS, 1'b1);

  logic [nte_pkg::NUM_NIB-1:0][nte_pkg::WORD_W-1:0] fac_d, fac_q;
  logic                                             vld_q;

  always_comb begin
    for (int unsigned j = 0; j < nte_pkg::NUM_NIB; j++) begin
      fac_d[j] = action_i ? NegTab[j][code_i[nte_pkg::NIB_W*j +: nte_pkg::NIB_W]]
                          : PosTab[j][code_i[nte_pkg::NIB_W*j +: nte_pkg::NIB_W]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    fac_q <= fac_d;
  end

  assign beat_o.vld = vld_q;
  assign beat_o.fac = fac_q;

endmodule

`default_nettype wire

// File: rtl/nibble_table_exponential_core.sv
`default_nettype none

// Table-driven exp(+c*code) or exp(-c*code), c = EMAX/65535, as unsigned
// fixed point with FRAC_BITS fraction bits. One code per cycle is taken
// (busy stays low); each result appears on result_o for one cycle with
// result_valid_o after its start beat, in order. Each result passes through
// this registered chain: nibble table lookup, the first 32x32
// multiply, two stages that each round the previous product and multiply
// by the next factor, and a final rounding stage. The receiver has no
// way to hold results back, so none must be missed.
module nibble_table_exponential_core #(
  parameter int unsigned EMAX      = nte_pkg::EMAX_DEF,
  parameter int unsigned FRAC_BITS = nte_pkg::FRAC_BITS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  output      logic                        busy,
  input  wire logic [nte_pkg::CODE_W-1:0]  code_i,
  input  wire logic                        action_i,
  output      logic [nte_pkg::WORD_W-1:0]  result_o,
  output      logic                        result_valid_o
);

  localparam logic [nte_pkg::WORD_W-1:0] One = nte_pkg::WORD_W'(1) << FRAC_BITS;

  nte_pkg::fac_beat_t lut_beat;

  logic                        v2_q, v3_q, v4_q, v5_q;
  logic [nte_pkg::PROD_W-1:0]  p2_d, p2_q, p3_d, p3_q, p4_d, p4_q;
  logic [nte_pkg::WORD_W-1:0]  f2_q, f3_q, f3b_q, res_d, res_q;

  assign busy = 1'b0;

  nte_lut #(
    .EMAX      (EMAX),
    .FRAC_BITS (FRAC_BITS)
  ) u_lut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .vld_i    (start & ~busy),
    .code_i   (code_i),
    .action_i (action_i),
    .beat_o   (lut_beat)
  );

  // left to right: ((f0*f1)*f2)*f3, rounding each product on the way in
  assign p2_d  = {32'd0, lut_beat.fac[0]} * {32'd0, lut_beat.fac[1]};
  assign p3_d  = {32'd0, nte_pkg::rnd(p2_q, FRAC_BITS)} * {32'd0, f2_q};
  assign p4_d  = {32'd0, nte_pkg::rnd(p3_q, FRAC_BITS)} * {32'd0, f3b_q};
  assign res_d = nte_pkg::rnd(p4_q, FRAC_BITS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      v2_q <= lut_beat.vld;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p2_q  <= p2_d;
    f2_q  <= lut_beat.fac[2];
    f3_q  <= lut_beat.fac[3];
    p3_q  <= p3_d;
    f3b_q <= f3_q;
    p4_q  <= p4_d;
    res_q <= res_d;
  end

  assign result_o       = res_q;
  assign result_valid_o = v5_q;

  a_lat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##5 result_valid_o)
    else $error("accepted beat did not come out after 5 cycles");

  a_src : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start && !busy, 5))
    else $error("result strobe without a matching start beat");

  a_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && code_i == '0) |-> ##5 (result_o == One))
    else $error("zero code must give exactly one");

  a_neg : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && action_i) |-> ##5 (result_o <= One))
    else $error("exp of negative argument above one");

  a_pos : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && !action_i) |-> ##5 (result_o >= One))
    else $error("exp of positive argument below one");

endmodule

`default_nettype wire
